>>> rtl/core/fpsm_pkg.sv
// Shared constants and the front-to-back command word of the five-point stencil block.
`timescale 1ns / 1ps
`default_nettype none

package fpsm_pkg;

    // Width of the grid_width register; it also bounds every column and count.
    localparam int COL_BITS = 6;

    localparam logic [COL_BITS-1:0] GRID_WIDTH_RESET = 6'd8;

    // Command for one accepted sample, built by the front and carried out by the back.
    typedef struct packed {
        logic                due;          // the position one row back is complete
        logic                last;         // flush the waiting positions after this one
        logic [COL_BITS-1:0] col;          // column of this sample and of the due centre
        logic                first;        // due centre lies in row zero
        logic [COL_BITS-1:0] flush_col;    // column of the oldest waiting position
        logic [COL_BITS-1:0] flush_d;      // its distance back in the history
        logic                flush_first;  // oldest waiting position lies in row zero
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/core/fpsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fpsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/fpsm_front.sv
// Front end: tracks grid position per accepted sample and builds its command.
`timescale 1ns / 1ps
`default_nettype none

module fpsm_front
    import fpsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [COL_BITS-1:0] i_width,
    input  wire logic                i_restart,
    input  wire logic                i_accept,
    input  wire logic                i_is_last,
    output      t_cmd                o_cmd
);

    logic [COL_BITS-1:0] r_col, n_col;
    logic                r_first, n_first;
    logic [COL_BITS-1:0] r_pending, n_pending;

    logic                due;
    logic                col_end;
    logic [COL_BITS-1:0] col_next;
    logic                first_after;
    logic [COL_BITS-1:0] pend_after;
    logic [COL_BITS:0]   flush_sum;

    always_comb begin
        due         = (r_pending == i_width);
        col_end     = (r_col == i_width - 1'b1);
        col_next    = col_end ? '0 : r_col + 1'b1;
        first_after = (due && col_end) ? 1'b0 : r_first;
        pend_after  = due ? r_pending : r_pending + 1'b1;
        // oldest waiting column: step back pend_after places, wrapping by width
        flush_sum   = {1'b0, col_next}
                    + ((col_next >= pend_after) ? {(COL_BITS+1){1'b0}} : {1'b0, i_width})
                    - {1'b0, pend_after};

        o_cmd.due         = due;
        o_cmd.last        = i_is_last;
        o_cmd.col         = r_col;
        o_cmd.first       = r_first;
        o_cmd.flush_col   = flush_sum[COL_BITS-1:0];
        o_cmd.flush_d     = pend_after - 1'b1;
        o_cmd.flush_first = first_after;

        n_col     = r_col;
        n_first   = r_first;
        n_pending = r_pending;
        if (i_restart || (i_accept && i_is_last)) begin
            n_col     = '0;
            n_first   = 1'b1;
            n_pending = '0;
        end else if (i_accept) begin
            n_col     = col_next;
            n_first   = first_after;
            n_pending = pend_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_first   <= 1'b1;
            r_pending <= '0;
        end else begin
            r_col     <= n_col;
            r_first   <= n_first;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fpsm_queue.sv
// Short register FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module fpsm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output      logic             o_full,
    input  wire logic             i_pop,
    output      logic             o_valid,
    output      logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

>>> rtl/core/fpsm_back.sv
// Back end: writes sample history and sequences stencil results through the history RAM.
`timescale 1ns / 1ps
`default_nettype none

module fpsm_back
    import fpsm_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int HIST_DEPTH  = 127
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [COL_BITS-1:0]    i_width,
    input  wire logic                   i_cmd_valid,
    input  wire t_cmd                   i_cmd,
    input  wire logic [SAMPLE_BITS-1:0] i_cmd_sample,
    output      logic                   o_cmd_pop,
    input  wire logic                   i_pop,
    output      logic                   o_valid,
    output      logic [SAMPLE_BITS+2:0] o_value,
    output      logic                   o_last
);

    localparam int OUT_BITS  = SAMPLE_BITS + 3;
    localparam int ADDR_BITS = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int RING      = 1 << ADDR_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    localparam logic [2:0] PH_CENTRE = 3'd0;
    localparam logic [2:0] PH_LEFT   = 3'd1;
    localparam logic [2:0] PH_RIGHT  = 3'd2;
    localparam logic [2:0] PH_UP     = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic                 r_state, n_state;
    logic [2:0]           r_phase, n_phase;
    logic [ADDR_BITS-1:0] r_wp, n_wp;
    logic [COL_BITS-1:0]  r_d, n_d;
    logic [COL_BITS-1:0]  r_c, n_c;
    logic                 r_first, n_first;
    logic                 r_in_flush, n_in_flush;
    logic                 r_do_flush, n_do_flush;
    logic [COL_BITS-1:0]  r_fl_c, n_fl_c;
    logic [COL_BITS-1:0]  r_fl_d, n_fl_d;
    logic                 r_fl_first, n_fl_first;
    logic [OUT_BITS-1:0]  r_acc, n_acc;
    logic                 r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]  r_out_value, n_out_value;
    logic                 r_out_last, n_out_last;

    logic                   ram_we;
    logic                   ram_re;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [COL_BITS:0]      rd_off;
    logic [OUT_BITS-1:0]    rd_ext;
    logic [OUT_BITS-1:0]    smp_ext;
    logic                   left_zero;
    logic                   right_zero;
    logic                   job_last;

    fpsm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (n_wp),
        .i_wdata (i_cmd_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        rd_ext     = {{3{ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
        smp_ext    = {{3{i_cmd_sample[SAMPLE_BITS-1]}}, i_cmd_sample};
        job_last   = r_in_flush && (r_d == '0);
        left_zero  = (r_c == '0);
        right_zero = (r_c == i_width - 1'b1) || job_last;

        n_state     = r_state;
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_d         = r_d;
        n_c         = r_c;
        n_first     = r_first;
        n_in_flush  = r_in_flush;
        n_do_flush  = r_do_flush;
        n_fl_c      = r_fl_c;
        n_fl_d      = r_fl_d;
        n_fl_first  = r_fl_first;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        rd_off      = {1'b0, r_d};

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    ram_we     = 1'b1;
                    n_wp       = r_wp + 1'b1;
                    n_fl_c     = i_cmd.flush_col;
                    n_fl_d     = i_cmd.flush_d;
                    n_fl_first = i_cmd.flush_first;
                    n_phase    = PH_CENTRE;
                    if (i_cmd.due) begin
                        // centre one row back, this sample is its lower neighbour
                        n_state    = ST_CALC;
                        n_d        = i_width;
                        n_c        = i_cmd.col;
                        n_first    = i_cmd.first;
                        n_in_flush = 1'b0;
                        n_do_flush = i_cmd.last;
                        n_acc      = {OUT_BITS{1'b0}} - smp_ext;
                    end else if (i_cmd.last) begin
                        n_state    = ST_CALC;
                        n_d        = i_cmd.flush_d;
                        n_c        = i_cmd.flush_col;
                        n_first    = i_cmd.flush_first;
                        n_in_flush = 1'b1;
                        n_do_flush = 1'b0;
                        n_acc      = '0;
                    end
                end
            end
            ST_CALC: begin
                case (r_phase)
                    PH_CENTRE: begin
                        ram_re  = 1'b1;
                        rd_off  = {1'b0, r_d};
                        n_phase = PH_LEFT;
                    end
                    PH_LEFT: begin
                        ram_re  = 1'b1;
                        rd_off  = {1'b0, r_d} + 1'b1;
                        n_acc   = r_acc + {rd_ext[OUT_BITS-3:0], 2'b00};
                        n_phase = PH_RIGHT;
                    end
                    PH_RIGHT: begin
                        ram_re  = 1'b1;
                        rd_off  = {1'b0, r_d} - 1'b1;
                        n_acc   = r_acc - (left_zero ? {OUT_BITS{1'b0}} : rd_ext);
                        n_phase = PH_UP;
                    end
                    PH_UP: begin
                        ram_re  = 1'b1;
                        rd_off  = {1'b0, r_d} + {1'b0, i_width};
                        n_acc   = r_acc - (right_zero ? {OUT_BITS{1'b0}} : rd_ext);
                        n_phase = PH_DONE;
                    end
                    PH_DONE: begin
                        // hold here until the output register is free
                        if (!r_out_valid || i_pop) begin
                            n_out_valid = 1'b1;
                            n_out_value = r_acc - (r_first ? {OUT_BITS{1'b0}} : rd_ext);
                            n_out_last  = job_last;
                            n_phase     = PH_CENTRE;
                            n_acc       = '0;
                            if (r_in_flush) begin
                                if (r_d == '0) begin
                                    n_state    = ST_IDLE;
                                    n_in_flush = 1'b0;
                                end else begin
                                    n_d = r_d - 1'b1;
                                    if (r_c == i_width - 1'b1) begin
                                        n_c     = '0;
                                        n_first = 1'b0;
                                    end else begin
                                        n_c = r_c + 1'b1;
                                    end
                                end
                            end else if (r_do_flush) begin
                                n_in_flush = 1'b1;
                                n_do_flush = 1'b0;
                                n_d        = r_fl_d;
                                n_c        = r_fl_c;
                                n_first    = r_fl_first;
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                        n_phase = PH_CENTRE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        ram_raddr = r_wp - ADDR_BITS'(rd_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_CENTRE;
            r_wp        <= '0;
            r_in_flush  <= 1'b0;
            r_do_flush  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_in_flush  <= n_in_flush;
            r_do_flush  <= n_do_flush;
            r_out_valid <= n_out_valid;
        end
        r_d         <= n_d;
        r_c         <= n_c;
        r_first     <= n_first;
        r_fl_c      <= n_fl_c;
        r_fl_d      <= n_fl_d;
        r_fl_first  <= n_fl_first;
        r_acc       <= n_acc;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

>>> rtl/core/five_point_stencil_matvec.sv
// Top level of the streaming five-point Laplacian stencil block.
//
//   channel   direction  handshake            word
//   -------   ---------  ---------            ----
//   sample    in         push / full          i_sample, i_is_last
//   result    out        empty / pop          o_stencil_value, o_last_result
//   config    in         i_cfg_we (no wait)   i_cfg_data (grid_width)
//
// The front accepts one word per cycle into a four-entry command queue while
// it has room. The back writes every word into the history RAM; a word that
// completes a position is followed by four reads through the single read port
// of the history RAM, and so is each flushed position after a last-marked
// word, up to grid_width of them.
// Reset is synchronous; the history RAM gets no clearing pass.
// A result held on the ports stalls the back at its final step; the front
// keeps taking words until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module five_point_stencil_matvec
    import fpsm_pkg::*;
#(
    parameter int MAX_WIDTH   = 63,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output      logic                          full,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_is_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [COL_BITS-1:0]           i_cfg_data,
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic signed [SAMPLE_BITS+2:0] o_stencil_value,
    output      logic                          o_last_result
);

    // two rows of history plus the centre's left neighbour
    localparam int HIST_DEPTH  = 2 * MAX_WIDTH + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int CMD_BITS    = $bits(t_cmd);
    localparam int QUEUE_BITS  = SAMPLE_BITS + CMD_BITS;

    logic [COL_BITS-1:0]    r_grid_width;
    logic [COL_BITS-1:0]    width_eff;
    logic                   accept;
    t_cmd                   front_cmd;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [QUEUE_BITS-1:0]  q_data;
    logic                   out_valid;

    // Hold the width register; any write restarts the grid in the front.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_grid_width <= i_cfg_data;
        end
    end

    // Map width zero to one and clip to the history the RAM can hold.
    always_comb begin
        if (r_grid_width == '0) begin
            width_eff = COL_BITS'(1);
        end else if (r_grid_width > COL_BITS'(MAX_WIDTH)) begin
            width_eff = COL_BITS'(MAX_WIDTH);
        end else begin
            width_eff = r_grid_width;
        end
    end

    assign accept = push && !q_full;
    assign full   = q_full;

    fpsm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (width_eff),
        .i_restart (i_cfg_we),
        .i_accept  (accept),
        .i_is_last (i_is_last),
        .o_cmd     (front_cmd)
    );

    // Carry the raw sample alongside its command.
    fpsm_queue #(
        .WIDTH (QUEUE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({i_sample, front_cmd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    fpsm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .HIST_DEPTH  (HIST_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (width_eff),
        .i_cmd_valid  (q_valid),
        .i_cmd        (t_cmd'(q_data[CMD_BITS-1:0])),
        .i_cmd_sample (q_data[QUEUE_BITS-1 -: SAMPLE_BITS]),
        .o_cmd_pop    (q_pop),
        .i_pop        (pop),
        .o_valid      (out_valid),
        .o_value      (o_stencil_value),
        .o_last       (o_last_result)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire

>>> rtl/core/fpsm_checker.sv
// Port-level checker for the five-point stencil block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fpsm_checker #(
    parameter int SAMPLE_BITS = 32
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   full,
    input wire logic                   empty,
    input wire logic                   pop,
    input wire logic [SAMPLE_BITS+2:0] o_stencil_value,
    input wire logic                   o_last_result
);

    localparam logic [SAMPLE_BITS+2:0] OUT_MIN = {1'b1, {(SAMPLE_BITS+2){1'b0}}};

    // Reset drops any waiting result.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // Reset drains the command queue.
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("queue full right after reset");

    // Hold a result that is not taken.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_stencil_value) && $stable(o_last_result)))
        else $error("waiting result changed or vanished");

    // The most negative code is out of reach of the stencil sum.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_stencil_value != OUT_MIN))
        else $error("stencil value out of range");

endmodule

bind five_point_stencil_matvec fpsm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fpsm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_stencil_value (o_stencil_value),
    .o_last_result   (o_last_result)
);

`default_nettype wire
